FILE: sv/srat_pkg.sv
// package for the source range association table: constants, payload types, status codes
package srat_pkg;

    localparam int ENTRIES      = 64;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int CNT_W        = $clog2(ENTRIES + 1);

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_FIND_AT  = 2'd1;
    localparam logic [1:0] OP_FIND     = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] source_id;
        logic [31:0] extent_offset;
        logic [31:0] extent_size;
        logic        has_focus;
        logic [31:0] focus_offset;
        logic [31:0] focus_size;
        logic [31:0] semantic_id;
        logic [31:0] query_offset;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_semantic;
        logic [15:0] result_source;
        logic [31:0] result_extent_offset;
        logic [31:0] result_extent_size;
        logic        result_has_focus;
        logic [31:0] result_focus_offset;
        logic [31:0] result_focus_size;
    } out_item_t;

    // one stored association
    typedef struct packed {
        logic [15:0] source;
        logic [31:0] extent_offset;
        logic [31:0] extent_size;
        logic        has_focus;
        logic [31:0] focus_offset;
        logic [31:0] focus_size;
        logic [31:0] semantic;
    } entry_t;

    // search token traveling down the chain
    typedef struct packed {
        logic             live;
        logic             have;
        logic             focused;
        logic [31:0]      best;
        logic [IDX_W-1:0] pick;
        entry_t           hit;
    } token_t;

endpackage

FILE: sv/srat_cell.sv
// one cell of the chain: holds one entry, matches it against the passing query
module srat_cell
    import srat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         query,
    input  logic             used,
    input  logic [IDX_W-1:0] slot,
    input  logic             wr_en,
    input  token_t           tok_in,
    output token_t           tok_out
);
    entry_t ent_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   same;
    logic   in_f;
    logic   in_e;
    logic [31:0] sz;
    logic [31:0] fo_q;
    logic [31:0] fs_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg.source        <= query.source_id;
            ent_reg.extent_offset <= query.extent_offset;
            ent_reg.extent_size   <= query.extent_size;
            ent_reg.has_focus     <= query.has_focus;
            ent_reg.focus_offset  <= fo_q;
            ent_reg.focus_size    <= fs_q;
            ent_reg.semantic      <= query.semantic_id;
        end
    end

    always_comb
    begin
        fo_q = query.has_focus ? query.focus_offset : 32'd0;
        fs_q = query.has_focus ? query.focus_size : 32'd0;
        same = ent_reg.source == query.source_id
            && ent_reg.extent_offset == query.extent_offset
            && ent_reg.extent_size == query.extent_size
            && ent_reg.has_focus == query.has_focus
            && ent_reg.focus_offset == fo_q && ent_reg.focus_size == fs_q;
        in_f = ent_reg.has_focus && query.query_offset >= ent_reg.focus_offset
            && (query.query_offset - ent_reg.focus_offset) < ent_reg.focus_size;
        in_e = query.query_offset >= ent_reg.extent_offset
            && (query.query_offset - ent_reg.extent_offset) < ent_reg.extent_size;
        sz = in_f ? ent_reg.focus_size : ent_reg.extent_size;
        tok_next = tok_in;
        if (tok_in.live && used)
        begin
            unique case (query.operation)
                OP_CREATE:
                    if (!tok_in.have && same)
                    begin
                        tok_next.have = 1'b1;
                        tok_next.pick = slot;
                        tok_next.hit  = ent_reg;
                    end
                OP_FIND_AT:
                    if ((in_f || in_e) && (!tok_in.have || (in_f && !tok_in.focused)
                        || (in_f == tok_in.focused && sz < tok_in.best)))
                    begin
                        tok_next.have    = 1'b1;
                        tok_next.focused = in_f;
                        tok_next.best    = sz;
                        tok_next.hit     = ent_reg;
                    end
                OP_FIND:
                    if (!tok_in.have && ent_reg.semantic == query.semantic_id)
                    begin
                        tok_next.have = 1'b1;
                        tok_next.hit  = ent_reg;
                    end
                default: tok_next = tok_in;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;
endmodule

FILE: sv/source_range_association_table_unit.sv
// top level: chain of entry cells, a search token walks one cell per cycle
// one item at a time: no new item is taken while a search or result is pending;
// the next is accepted the cycle after the result is taken
// reset: entry count and control clear asynchronously; entry contents undefined
// until written, cells at or past the count never take part
module source_range_association_table_unit
    import srat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    in_item_t        query_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_reg, out_next;
    logic            launch_reg;
    token_t          head_tok;
    token_t          tok [ENTRIES+1];
    logic [ENTRIES-1:0] wr_en;
    logic            done_tok;
    token_t          fin;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // token injected at the head of the chain
    always_comb
    begin
        head_tok      = '0;
        head_tok.live = launch_reg;
    end

    assign tok[0] = head_tok;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            srat_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .query   (query_reg),
                .used    (CNT_W'(g) < count_reg),
                .slot    (IDX_W'(g)),
                .wr_en   (wr_en[g]),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    assign fin      = tok[ENTRIES];
    assign done_tok = fin.live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            launch_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            launch_reg    <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            query_reg <= in_item;
        out_reg <= out_next;
    end

    // finish: build the result, write the entry for a create
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (done_tok)
                begin
                    out_next        = '0;
                    out_next.status = ST_NOT_FOUND;
                    unique case (query_reg.operation)
                        OP_CREATE:
                            if (fin.have)
                            begin
                                // rewrite the first matching cell in place
                                out_next.status = ST_REPLACED;
                                wr_en[fin.pick] = 1'b1;
                            end
                            else if (count_reg == CNT_W'(ENTRIES))
                                out_next.status = ST_FULL;
                            else
                            begin
                                out_next.status = ST_INSERTED;
                                wr_en[count_reg[IDX_W-1:0]] = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        OP_FIND_AT:
                            if (fin.have)
                            begin
                                out_next.status          = ST_FOUND;
                                out_next.result_semantic = fin.hit.semantic;
                            end
                        OP_FIND:
                            if (fin.have)
                            begin
                                out_next.status               = ST_FOUND;
                                out_next.result_source        = fin.hit.source;
                                out_next.result_extent_offset = fin.hit.extent_offset;
                                out_next.result_extent_size   = fin.hit.extent_size;
                                out_next.result_has_focus     = fin.hit.has_focus;
                                out_next.result_focus_offset  = fin.hit.focus_offset;
                                out_next.result_focus_size    = fin.hit.focus_size;
                            end
                        default: out_next.status = ST_NOT_FOUND;
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = S_DONE;
                end
            S_DONE:
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

FILE: sv/srat_checker.sv
// port checker for the association table, bound to the top level
module srat_checker
    import srat_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= ST_FULL)
        else $error("bad status");
    a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");
endmodule

bind source_range_association_table_unit srat_checker u_srat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
